[src/bll_pkg.sv]
// ----------------------------------------------------------------------------
// bll_pkg
// Shared types and codes for the bounded letter list engine: request and
// result beats, per-cell control, opcode and status codes, and the FSM states.
// ----------------------------------------------------------------------------
package bll_pkg;

  // opcodes
  localparam logic [2:0] OP_SHOW   = 3'd0;
  localparam logic [2:0] OP_SEARCH = 3'd1;
  localparam logic [2:0] OP_FRONT  = 3'd2;
  localparam logic [2:0] OP_BACK   = 3'd3;
  localparam logic [2:0] OP_AT     = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_BAD_POS = 2'd2;

  // reset contents and show length
  localparam int         RESET_COUNT = 5;
  localparam int         SHOW_LIMIT  = 16;
  localparam logic [7:0] LETTER_A    = 8'h41;

  // request beat
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] letter;
    logic [4:0] slot;
  } bll_req_t;

  // result beat
  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [4:0] where_found;
    logic [7:0] shown_letter;
    logic       last;
  } bll_res_t;

  // control broadcast to every cell
  typedef struct packed {
    logic       rotate;
    logic       insert;
    logic [7:0] letter;
  } bll_cell_ctrl_t;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_WALK
  } bll_state_t;

endpackage

[src/bounded_letter_list_engine.sv]
// ----------------------------------------------------------------------------
// bounded_letter_list_engine
// Ordered list of byte letters held in a row of cells, with show, search
// and insert at front, back or a 1-based position.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (op, letter, slot) is taken at a clock edge with start high
//   and busy low. Result beats come out on result, each marked by strobe for
//   exactly one cycle; the receiver cannot hold them off.
//   On an insert the cells at and above the position load or shift up in
//   parallel and the single result beat shows in the cycle after the request;
//   busy stays low, so a new request may follow in the next cycle.
//   Show and search rotate the whole row of CAPACITY cells past the head
//   cell, one place per cycle, with busy high throughout, and the list ends
//   in its original order. Show emits one beat per held entry (at most 16)
//   as each passes the head, and marks the final beat with last. An empty
//   show gives one beat at once. Search gives one beat at the end of the
//   rotation.
//   Unknown opcodes are taken and ignored.
//   Reset loads A to E into the first cells (fewer if the row is shorter),
//   sets the count to match, and returns to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bounded_letter_list_engine import bll_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  bll_req_t request,
  output logic     busy,
  output logic     strobe,
  output bll_res_t result
);

  localparam int CW         = $clog2(CAPACITY + 1);
  localparam int IW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SW         = (CW > 5) ? CW + 1 : 6;
  localparam int RESET_FILL = (CAPACITY < RESET_COUNT) ? CAPACITY : RESET_COUNT;

  localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_IX = IW'(CAPACITY - 1);

  bll_state_t     state, state_next;
  logic [IW-1:0]  cnt;
  logic [CW-1:0]  fill;
  logic           walk_show;
  logic [7:0]     key;
  logic [CW-1:0]  walk_n;
  logic           hit;
  logic [CW-1:0]  hit_pos;

  logic [7:0]     vals [CAPACITY];
  bll_cell_ctrl_t ctrl;
  logic [CW-1:0]  ins_pos;

  logic           accept, is_insert, full, slot_ok, ins_ok;
  logic [CW-1:0]  show_n, pos_c;
  logic           within_fill, within_n, hit_now, last_step;
  logic           emit;
  bll_res_t       res_next;

  // row of cells, head at index zero, ring closed for rotation
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [7:0] below;
    if (g == 0) begin : g_head
      assign below = 8'h00;
    end else begin : g_body
      assign below = vals[g-1];
    end
    bll_cell #(.CW(CW), .IDX(g)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .ins_pos (ins_pos),
      .below   (below),
      .above   (vals[(g + 1) % CAPACITY]),
      .value   (vals[g])
    );
  end

  // request decode
  assign accept    = start && !busy;
  assign is_insert = (request.op == OP_FRONT) || (request.op == OP_BACK) ||
                     (request.op == OP_AT);
  assign full      = (fill == CAP_C);
  assign slot_ok   = (SW'(request.slot) != SW'(0)) &&
                     (SW'(request.slot) <= SW'(fill) + SW'(1));
  assign ins_ok    = accept && is_insert && !full &&
                     ((request.op != OP_AT) || slot_ok);
  assign show_n    = (SW'(fill) > SW'(SHOW_LIMIT)) ? CW'(SHOW_LIMIT) : fill;

  // insert position, 0-based
  always_comb begin
    unique case (request.op)
      OP_FRONT: ins_pos = '0;
      OP_BACK:  ins_pos = fill;
      default:  ins_pos = CW'(request.slot - 5'd1);
    endcase
  end

  // walk bookkeeping
  assign pos_c       = CW'(cnt) + CW'(1);
  assign within_fill = (CW'(cnt) < fill);
  assign within_n    = (CW'(cnt) < walk_n);
  assign hit_now     = !walk_show && !hit && within_fill && (vals[0] == key);
  assign last_step   = (cnt == LAST_IX);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (((request.op == OP_SHOW) && (show_n != '0)) ||
                       (request.op == OP_SEARCH))) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (last_step) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    busy        = (state == S_WALK);
    ctrl.rotate = (state == S_WALK);
    ctrl.insert = ins_ok;
    ctrl.letter = request.letter;
  end

  // result beat selection
  always_comb begin
    emit     = 1'b0;
    res_next = '0;
    res_next.last = 1'b1;
    if (state == S_IDLE) begin
      if (accept) begin
        unique case (request.op) inside
          OP_SHOW: begin
            emit = (show_n == '0);
          end
          OP_FRONT, OP_BACK, OP_AT: begin
            emit = 1'b1;
            if (full) begin
              res_next.status = STAT_FULL;
            end else if ((request.op == OP_AT) && !slot_ok) begin
              res_next.status = STAT_BAD_POS;
            end else begin
              res_next.status = STAT_OK;
            end
          end
          default: emit = 1'b0;
        endcase
      end
    end else if (walk_show) begin
      emit                  = within_n;
      res_next.where_found  = 5'(pos_c);
      res_next.shown_letter = vals[0];
      res_next.last         = (pos_c == walk_n);
    end else begin
      emit                 = last_step;
      res_next.found       = hit || hit_now;
      res_next.where_found = hit ? 5'(hit_pos) : (hit_now ? 5'(pos_c) : 5'd0);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fill   <= CW'(RESET_FILL);
      cnt    <= '0;
      hit    <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
      if (ins_ok) begin
        fill <= fill + CW'(1);
      end
      if (state == S_IDLE) begin
        cnt <= '0;
        hit <= 1'b0;
      end else begin
        cnt <= cnt + IW'(1);
        if (hit_now) begin
          hit <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      walk_show <= (request.op == OP_SHOW);
      key       <= request.letter;
      walk_n    <= show_n;
    end
    if (hit_now) begin
      hit_pos <= pos_c;
    end
    if (emit) begin
      result <= res_next;
    end
  end

  // count never passes the row length
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CAP_C)
    else $error("fill count above capacity");

  // an insert into a full list reports full on the next beat
  a_full_report: assert property (@(posedge clk) disable iff (rst)
    accept && is_insert && full |=> strobe && (result.status == STAT_FULL))
    else $error("full insert not reported");

  // an insert never lands during a walk
  a_no_insert_walk: assert property (@(posedge clk) disable iff (rst)
    busy |-> !ctrl.insert)
    else $error("insert during rotation");

  // the walk ends after one full turn of the ring
  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) && last_step |=> (state == S_IDLE))
    else $error("walk did not end after one turn");

  // a search gives exactly one beat, marked last, at the end of the turn
  a_search_beat: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) && !walk_show && last_step |=> strobe && result.last)
    else $error("search result missing");

endmodule

[src/bll_cell.sv]
// ----------------------------------------------------------------------------
// bll_cell
// One list entry. Rotates toward the head during a walk, or on an insert
// either loads the new letter, takes the entry from the cell below it, or holds.
// ----------------------------------------------------------------------------
module bll_cell import bll_pkg::*; #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  bll_cell_ctrl_t ctrl,
  input  logic [CW-1:0]  ins_pos,
  input  logic [7:0]     below,
  input  logic [7:0]     above,
  output logic [7:0]     value
);

  localparam logic [7:0]    RESET_VAL = (IDX < RESET_COUNT) ? 8'(LETTER_A + IDX) : 8'h00;
  localparam logic [CW-1:0] MY_POS    = CW'(IDX);

  // entry register: rotate, load or shift up
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= RESET_VAL;
    end else if (ctrl.rotate) begin
      value <= above;
    end else if (ctrl.insert) begin
      if (MY_POS == ins_pos) begin
        value <= ctrl.letter;
      end else if (MY_POS > ins_pos) begin
        value <= below;
      end
    end
  end

endmodule
